### hdl/pprgb_pkg.sv
// Package for the packed pixel to RGB888 converter: beat types, format codes,
// conversion coefficients and the clamp helper. No dependencies.
package pprgb_pkg;

  // pixel_format register codes
  localparam logic [1:0] FMT_YUYV   = 2'd0;
  localparam logic [1:0] FMT_UYVY   = 2'd1;
  localparam logic [1:0] FMT_RGB565 = 2'd2;
  localparam logic [1:0] FMT_RSVD   = 2'd3;

  // YUV to RGB coefficients, 8 fractional bits
  localparam logic signed [17:0] COEF_RV = 18'sd359;
  localparam logic signed [17:0] COEF_GU = 18'sd88;
  localparam logic signed [17:0] COEF_GV = 18'sd183;
  localparam logic signed [17:0] COEF_BU = 18'sd454;

  // RGB565 red field mask
  localparam logic [7:0] MASK_R565 = 8'd248;

  typedef struct packed {
    logic [7:0] byte_zero;
    logic [7:0] byte_one;
    logic [7:0] byte_two;
    logic [7:0] byte_three;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_of_pair;
  } out_beat_t;

  // Floor-shift a sum by 8 and clamp to 0..255
  function automatic logic [7:0] clamp_shift8(input logic signed [18:0] s);
    logic signed [10:0] q;
    logic [7:0]         res;
    q = s[18:8];
    if (q < 11'sd0) begin
      res = 8'd0;
    end else if (q > 11'sd255) begin
      res = 8'd255;
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

### hdl/packed_pixel_to_rgb_converter_top.sv
// Top level of the packed pixel to RGB888 converter: group register, pixel
// issue and a three-stage conversion pipeline. Depends on pprgb_pkg.

// Takes one 4-byte packed group per input beat (YUYV, UYVY or little-endian
// RGB565, chosen by the pixel_format register) and delivers two RGB888 pixels,
// one per output beat, first pixel with last_of_pair low. The output channel
// moves one pixel per cycle while out_ready is high; a new group is taken as
// the previous group issues its second pixel into the first pipeline stage.
// Groups accepted while pixel_format holds the unused code 3 are dropped and
// produce no output. pixel_format may only be written while the block is idle.
module packed_pixel_to_rgb_converter_top
  import pprgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_beat_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_beat_t  out_data
);

  // one pixel's operands after issue
  typedef struct packed {
    logic       is_rgb;
    logic [7:0] y_lo;
    logic [7:0] u_hi;
    logic [7:0] v;
    logic       last;
  } pix_t;

  // products or expanded RGB565 channels
  typedef struct packed {
    logic                is_rgb;
    logic [7:0]          y;
    logic signed [17:0]  rp;
    logic signed [17:0]  gp;
    logic signed [17:0]  bp;
    logic [7:0]          r565;
    logic [7:0]          g565;
    logic [7:0]          b565;
    logic                last;
  } prod_t;

  logic [1:0] fmt_r;
  in_beat_t   grp_r;
  logic [1:0] grp_fmt_r;
  logic       grp_vld_r;
  logic       sel_r;
  pix_t       s1_r, s1_nxt;
  logic       s1_vld_r;
  prod_t      s2_r, s2_nxt;
  logic       s2_vld_r;
  out_beat_t  s3_r, s3_nxt;
  logic       s3_vld_r;
  logic       ld1, ld2, ld3;
  logic       in_acc;

  // stage load enables, a bubble in front lets a stage load
  assign ld3 = !s3_vld_r || out_ready;
  assign ld2 = !s2_vld_r || ld3;
  assign ld1 = !s1_vld_r || ld2;

  assign cfg_ready = 1'b1;
  assign in_ready  = !grp_vld_r || (ld1 && sel_r);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = s3_vld_r;
  assign out_data  = s3_r;

  // hold the format register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_YUYV;
    end else if (cfg_valid) begin
      fmt_r <= cfg_data;
    end
  end

  // hold the group, issue its two pixels
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_vld_r <= 1'b0;
      sel_r     <= 1'b0;
    end else if (in_acc) begin
      grp_vld_r <= (fmt_r != FMT_RSVD);
      sel_r     <= 1'b0;
    end else if (grp_vld_r && ld1) begin
      grp_vld_r <= !sel_r;
      sel_r     <= !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      grp_r     <= in_data;
      grp_fmt_r <= fmt_r;
    end
  end

  // pick the bytes of the current pixel
  always_comb begin
    s1_nxt.is_rgb = (grp_fmt_r == FMT_RGB565);
    s1_nxt.last   = sel_r;
    case (grp_fmt_r)
      FMT_UYVY: begin
        s1_nxt.y_lo = sel_r ? grp_r.byte_three : grp_r.byte_one;
        s1_nxt.u_hi = grp_r.byte_zero;
        s1_nxt.v    = grp_r.byte_two;
      end
      FMT_RGB565: begin
        s1_nxt.y_lo = sel_r ? grp_r.byte_two : grp_r.byte_zero;
        s1_nxt.u_hi = sel_r ? grp_r.byte_three : grp_r.byte_one;
        s1_nxt.v    = 8'd0;
      end
      default: begin
        s1_nxt.y_lo = sel_r ? grp_r.byte_two : grp_r.byte_zero;
        s1_nxt.u_hi = grp_r.byte_one;
        s1_nxt.v    = grp_r.byte_three;
      end
    endcase
  end

  // form chroma products and RGB565 channels
  always_comb begin
    logic signed [17:0] u_w;
    logic signed [17:0] v_w;
    u_w = 18'($signed({~s1_r.u_hi[7], s1_r.u_hi[6:0]}));
    v_w = 18'($signed({~s1_r.v[7], s1_r.v[6:0]}));
    s2_nxt.is_rgb = s1_r.is_rgb;
    s2_nxt.y      = s1_r.y_lo;
    s2_nxt.rp     = v_w * COEF_RV;
    s2_nxt.gp     = -(u_w * COEF_GU) - (v_w * COEF_GV);
    s2_nxt.bp     = u_w * COEF_BU;
    s2_nxt.r565   = s1_r.u_hi & MASK_R565;
    s2_nxt.g565   = {s1_r.u_hi[2:0], s1_r.y_lo[7:5], 2'b00};
    s2_nxt.b565   = {s1_r.y_lo[4:0], 3'b000};
    s2_nxt.last   = s1_r.last;
  end

  // add luma, shift and clamp, or pass the RGB565 channels through
  always_comb begin
    logic signed [18:0] y_w;
    y_w = $signed({3'b000, s2_r.y, 8'h00});
    s3_nxt.last_of_pair = s2_r.last;
    if (s2_r.is_rgb) begin
      s3_nxt.red   = s2_r.r565;
      s3_nxt.green = s2_r.g565;
      s3_nxt.blue  = s2_r.b565;
    end else begin
      s3_nxt.red   = clamp_shift8(y_w + 19'(s2_r.rp));
      s3_nxt.green = clamp_shift8(y_w + 19'(s2_r.gp));
      s3_nxt.blue  = clamp_shift8(y_w + 19'(s2_r.bp));
    end
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      if (ld1) begin
        s1_vld_r <= grp_vld_r;
      end
      if (ld2) begin
        s2_vld_r <= s1_vld_r;
      end
      if (ld3) begin
        s3_vld_r <= s2_vld_r;
      end
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_r <= s1_nxt;
    end
    if (ld2) begin
      s2_r <= s2_nxt;
    end
    if (ld3) begin
      s3_r <= s3_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a held group never carries the unused format
  a_grp_fmt: assert property (@(posedge clk) disable iff (!rst_n)
    grp_vld_r |-> (grp_fmt_r != FMT_RSVD))
    else $error("group register holds unused format");

  // the second-pixel flag only stands with a held group
  a_sel_grp: assert property (@(posedge clk) disable iff (!rst_n)
    sel_r |-> grp_vld_r)
    else $error("pixel select set without a group");

  // a new beat never overwrites a group whose pixels are not all issued
  a_no_ovwr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && grp_vld_r) |-> (sel_r && ld1))
    else $error("group overwritten before issue");

  // once the first pixel issues, stage 1 holds it and the second pixel is selected next
  a_pair_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (grp_vld_r && !sel_r && ld1) |=> (s1_vld_r && !s1_r.last && sel_r))
    else $error("first pixel issue out of order");
`endif

endmodule
